// ----- hdl/rfq_pkg.sv -----
package rfq_pkg;

  // field widths
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned PPM_W    = 22;
  localparam int unsigned DEPTH_W  = 13;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned SCALED_W = 18;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PROD_W   = DELAY_W + PPM_W;

  // clock scale limits and rounding
  localparam logic [PPM_W-1:0] PPM_RESET = 22'd1000000;
  localparam logic [PPM_W-1:0] PPM_MIN   = 22'd200000;
  localparam logic [PPM_W-1:0] PPM_MAX   = 22'd3000000;
  localparam logic [PPM_W-1:0] PPM_HALF  = 22'd500000;

  // divide by one million: drop six low bits, then divide by 5^6 through a reciprocal
  localparam int unsigned        PRE_SHIFT   = 6;
  localparam int unsigned        DIVIDEND_W  = PROD_W - PRE_SHIFT;
  localparam int unsigned        RECIP_SHIFT = 32;
  localparam int unsigned        QUOT_W      = 19;
  localparam logic [QUOT_W-1:0]  RECIP_MUL   = 19'd274877;
  localparam logic [13:0]        RECIP_DIV   = 14'd15625;

  // event decoding
  localparam logic [7:0] DELAY_ONLY_ADDR = 8'hFF;
  localparam logic [1:0] MASK_BOTH       = 2'h3;
  localparam logic [1:0] MASK_FIRST      = 2'h1;
  localparam logic [1:0] MASK_NONE       = 2'h0;

  // watermark resets
  localparam logic [DEPTH_W-1:0] HIGH_WATER_RESET = 13'd3968;
  localparam logic [DEPTH_W-1:0] LOW_WATER_RESET  = 13'd256;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_RESET = 2'd2
  } rfq_cmd_e;

  typedef enum logic [1:0] {
    REG_CLOCK_SCALE = 2'd0,
    REG_SPLIT_MODE  = 2'd1,
    REG_HIGH_WATER  = 2'd2,
    REG_LOW_WATER   = 2'd3
  } rfq_reg_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       host_connected;
    logic       keep_stats;
  } rfq_item_t;

  typedef struct packed {
    logic               split_mode;
    logic [DEPTH_W-1:0] pause_level;
    logic [DEPTH_W-1:0] resume_level;
  } rfq_cfg_t;

  typedef struct packed {
    logic               event_valid;
    logic [1:0]         target_sel;
    logic [4:0]         reg_addr;
    logic [7:0]         reg_value;
    logic [DEPTH_W-1:0] queue_depth;
    logic [SUM_W-1:0]   queued_cycles;
    logic [DEPTH_W-1:0] peak_depth;
    logic               flow_paused;
    logic               dropped_oldest;
    logic [TOTAL_W-1:0] event_tally;
    logic               streaming;
  } rfq_status_t;

endpackage

// ----- hdl/rfq_store.sv -----
module rfq_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned WW    = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [WW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [WW-1:0] rdata_o
);

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_q;
  logic [WW-1:0] wd_q;
  logic          byp_q;

  // event ring, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
    wd_q <= wdata_i;
  end

  // forward a write that lands on the address being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? wd_q : rd_q;

endmodule

// ----- hdl/rfq_core.sv -----
module rfq_core #(
  parameter int unsigned QUEUE_DEPTH = 4096,
  parameter int unsigned AW          = 12,
  parameter int unsigned CW          = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  rfq_pkg::rfq_item_t         item_i,
  input  rfq_pkg::rfq_cfg_t          cfg_i,
  input  logic [rfq_pkg::WORD_W-1:0] head_word_i,
  output logic                       we_o,
  output logic [AW-1:0]              waddr_o,
  output logic [rfq_pkg::WORD_W-1:0] wdata_o,
  output logic [AW-1:0]              raddr_o,
  output rfq_pkg::rfq_status_t       res_o,
  output logic [rfq_pkg::DELAY_W-1:0] delay_o
);
  import rfq_pkg::*;

  localparam int unsigned CMPW = (CW > DEPTH_W) ? CW : DEPTH_W;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == AW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  logic [7:0]         asm_q [3];
  logic [1:0]         cnt_q, cnt_d;
  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      tail_q, tail_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [SUM_W-1:0]   sum_q, sum_d, sum_drop;
  logic [CW-1:0]      peak_q, peak_d;
  logic               halt_q, halt_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               stream_q, stream_d;
  logic               asm_we;
  logic               flow_eval;
  logic               dropped;
  logic [DELAY_W-1:0] new_delay;
  logic [DELAY_W-1:0] head_delay;
  logic [7:0]         head_addr;
  logic [7:0]         head_value;

  assign new_delay  = {asm_q[1], asm_q[0]};
  assign head_delay = head_word_i[DELAY_W-1:0];
  assign head_addr  = head_word_i[23:16];
  assign head_value = head_word_i[31:24];

  // command decode and queue update
  always_comb begin
    cnt_d     = cnt_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    peak_d    = peak_q;
    total_d   = total_q;
    stream_d  = stream_q;
    asm_we    = 1'b0;
    flow_eval = 1'b0;
    dropped   = 1'b0;
    we_o      = 1'b0;
    wdata_o   = {item_i.data_byte, asm_q[2], new_delay};
    sum_drop  = sum_q;
    delay_o   = '0;
    res_o     = '0;
    if (fire_i) begin
      case (item_i.cmd)
        CMD_BYTE: begin
          if (cnt_q != 2'd3) begin
            asm_we = 1'b1;
            cnt_d  = cnt_q + 2'd1;
          end else begin
            cnt_d   = '0;
            total_d = total_q + 1'b1;
            // full ring: the oldest event gives way
            if (fill_q == CW'(QUEUE_DEPTH)) begin
              dropped  = 1'b1;
              head_d   = wrap_inc(head_q);
              sum_drop = (sum_q >= SUM_W'(head_delay)) ? sum_q - SUM_W'(head_delay) : '0;
            end else begin
              fill_d = fill_q + 1'b1;
            end
            we_o      = 1'b1;
            tail_d    = wrap_inc(tail_q);
            sum_d     = sum_drop + SUM_W'(new_delay);
            peak_d    = (fill_d > peak_q) ? fill_d : peak_q;
            flow_eval = 1'b1;
            stream_d  = 1'b1;
          end
        end
        CMD_POP: begin
          if (fill_q != '0) begin
            head_d            = wrap_inc(head_q);
            fill_d            = fill_q - 1'b1;
            sum_d             = (sum_q >= SUM_W'(head_delay)) ? sum_q - SUM_W'(head_delay) : '0;
            res_o.event_valid = 1'b1;
            delay_o           = head_delay;
            if (head_addr != DELAY_ONLY_ADDR) begin
              res_o.target_sel = cfg_i.split_mode ? MASK_BOTH : MASK_FIRST;
              res_o.reg_addr   = head_addr[4:0];
              res_o.reg_value  = head_value;
            end else begin
              res_o.target_sel = MASK_NONE;
            end
            flow_eval = 1'b1;
          end
        end
        CMD_RESET: begin
          cnt_d    = '0;
          total_d  = item_i.keep_stats ? total_q : '0;
          stream_d = 1'b0;
          head_d   = '0;
          tail_d   = '0;
          fill_d   = '0;
          sum_d    = '0;
          peak_d   = '0;
        end
        default: begin
        end
      endcase
    end
    // status after this transfer
    res_o.queue_depth    = DEPTH_W'(fill_d);
    res_o.queued_cycles  = sum_d;
    res_o.peak_depth     = DEPTH_W'(peak_d);
    res_o.flow_paused    = halt_d;
    res_o.dropped_oldest = dropped;
    res_o.event_tally    = total_d;
    res_o.streaming      = stream_d;
  end

  // watermark hysteresis on the depth after this transfer
  always_comb begin
    halt_d = halt_q;
    if (fire_i && (item_i.cmd == CMD_RESET)) begin
      halt_d = 1'b0;
    end else if (flow_eval) begin
      if (!item_i.host_connected) begin
        halt_d = 1'b0;
      end else if (!halt_q && (CMPW'(fill_d) >= CMPW'(cfg_i.pause_level))) begin
        halt_d = 1'b1;
      end else if (halt_q && (CMPW'(fill_d) <= CMPW'(cfg_i.resume_level))) begin
        halt_d = 1'b0;
      end
    end
  end

  assign waddr_o = tail_q;
  assign raddr_o = head_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
      peak_q   <= '0;
      halt_q   <= 1'b0;
      total_q  <= '0;
      stream_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      peak_q   <= peak_d;
      halt_q   <= halt_d;
      total_q  <= total_d;
      stream_q <= stream_d;
    end
  end

  // assembler bytes
  always_ff @(posedge clk_i) begin
    if (asm_we) begin
      asm_q[cnt_q] <= item_i.data_byte;
    end
  end

endmodule

// ----- hdl/rfq_scale.sv -----
module rfq_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  rfq_pkg::rfq_status_t         res_i,
  input  logic [rfq_pkg::DELAY_W-1:0]  delay_i,
  input  logic [rfq_pkg::PPM_W-1:0]    ppm_i,
  output logic                         valid_o,
  output rfq_pkg::rfq_status_t         res_o,
  output logic [rfq_pkg::SCALED_W-1:0] scaled_o
);
  import rfq_pkg::*;

  localparam int unsigned WIDE_W = DIVIDEND_W + QUOT_W;

  logic                  a_valid_q, b_valid_q, c_valid_q;
  rfq_status_t           a_res_q, b_res_q, c_res_q;
  logic                  a_nz_q, b_nz_q;
  logic [PROD_W-1:0]     a_prod_q;
  logic [DIVIDEND_W-1:0] b_x_q;
  logic [QUOT_W-1:0]     b_qe_q;
  logic [SCALED_W-1:0]   c_scaled_q;

  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] dividend;
  logic [WIDE_W-1:0]     wide;
  logic [QUOT_W-1:0]     quot_est;
  logic [DIVIDEND_W-1:0] rem;
  logic [QUOT_W-1:0]     quot;
  logic [SCALED_W-1:0]   scaled;

  // delay times scale plus half a million for rounding
  assign prod = PROD_W'(delay_i) * PROD_W'(ppm_i) + PROD_W'(PPM_HALF);

  // quotient estimate, low by at most one
  assign dividend = a_prod_q[PROD_W-1:PRE_SHIFT];
  assign wide     = WIDE_W'(dividend) * WIDE_W'(RECIP_MUL);
  assign quot_est = QUOT_W'(wide >> RECIP_SHIFT);

  // one correction step and the floor of one for a nonzero delay
  assign rem  = b_x_q - DIVIDEND_W'(DIVIDEND_W'(b_qe_q) * DIVIDEND_W'(RECIP_DIV));
  assign quot = (rem >= DIVIDEND_W'(RECIP_DIV)) ? b_qe_q + 1'b1 : b_qe_q;
  always_comb begin
    if (!b_nz_q) begin
      scaled = '0;
    end else if (quot == '0) begin
      scaled = SCALED_W'(1);
    end else begin
      scaled = SCALED_W'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_res_q    <= res_i;
      a_nz_q     <= (delay_i != '0);
      a_prod_q   <= prod;
      b_res_q    <= a_res_q;
      b_nz_q     <= a_nz_q;
      b_x_q      <= dividend;
      b_qe_q     <= quot_est;
      c_res_q    <= b_res_q;
      c_scaled_q <= scaled;
    end
  end

  assign valid_o  = c_valid_q;
  assign res_o    = c_res_q;
  assign scaled_o = c_scaled_q;

endmodule

// ----- hdl/register_event_framer_queue_unit.sv -----
// path: an input transfer is registered, updates the queue and then passes the scaling stages
// before its result is offered; every stage holds while the output is stalled
// throughput: one item per cycle while the output is not stalled; the ring is read ahead at the
// next head address and the delay scaling runs in three stages behind the queue update
// reset: rst_ni is asynchronous and clears the queue pointers, counters and flags at once;
// the event ring is not cleared and needs no clearing pass
module register_event_framer_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration writes
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [21:0]   cfg_wdata_i,
  // input stream
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [15:0]   s_axis_tdata_i,  // data_byte, host_connected, keep_stats
  input  logic [1:0]    s_axis_tuser_i,  // cmd
  // result stream
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // target_sel, reg_addr, reg_value, scaled_delay, queue_depth, queued_cycles,
  // peak_depth, flow_paused, dropped_oldest, event_tally, streaming
  output logic [127:0]  m_axis_tdata_o,
  output logic          m_axis_tuser_o   // event_valid
);
  import rfq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic               in_valid_q;
  rfq_item_t          in_item_q;
  logic               en;
  logic               fire;
  rfq_cfg_t           cfg_q;
  logic [PPM_W-1:0]   ppm_q;
  logic [PPM_W-1:0]   ppm_clamped;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [WORD_W-1:0]  wdata;
  logic [WORD_W-1:0]  head_word;
  rfq_status_t        core_res;
  logic [DELAY_W-1:0] core_delay;
  logic               out_valid;
  rfq_status_t        out_res;
  logic [SCALED_W-1:0] out_scaled;

  // pipeline advances unless a result waits untaken
  assign en              = !out_valid || m_axis_tready_i;
  assign fire            = in_valid_q && en;
  assign s_axis_tready_o = !in_valid_q || en;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (en) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q.cmd            <= s_axis_tuser_i;
      in_item_q.data_byte      <= s_axis_tdata_i[7:0];
      in_item_q.host_connected <= s_axis_tdata_i[8];
      in_item_q.keep_stats     <= s_axis_tdata_i[9];
    end
  end

  // clock scale is clamped as it is written
  always_comb begin
    if (cfg_wdata_i < PPM_MIN) begin
      ppm_clamped = PPM_MIN;
    end else if (cfg_wdata_i > PPM_MAX) begin
      ppm_clamped = PPM_MAX;
    end else begin
      ppm_clamped = cfg_wdata_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q              <= PPM_RESET;
      cfg_q.split_mode   <= 1'b0;
      cfg_q.pause_level  <= HIGH_WATER_RESET;
      cfg_q.resume_level <= LOW_WATER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLOCK_SCALE: ppm_q              <= ppm_clamped;
        REG_SPLIT_MODE:  cfg_q.split_mode   <= cfg_wdata_i[0];
        REG_HIGH_WATER:  cfg_q.pause_level  <= cfg_wdata_i[DEPTH_W-1:0];
        REG_LOW_WATER:   cfg_q.resume_level <= cfg_wdata_i[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfq_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_item_q),
    .cfg_i       (cfg_q),
    .head_word_i (head_word),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .res_o       (core_res),
    .delay_o     (core_delay)
  );

  rfq_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .WW    (WORD_W)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (head_word)
  );

  rfq_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (fire),
    .res_i    (core_res),
    .delay_i  (core_delay),
    .ppm_i    (ppm_q),
    .valid_o  (out_valid),
    .res_o    (out_res),
    .scaled_o (out_scaled)
  );

  // result transfer packing
  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tuser_o  = out_res.event_valid;
  assign m_axis_tdata_o  = {6'b0,
                            out_res.streaming,
                            out_res.event_tally,
                            out_res.dropped_oldest,
                            out_res.flow_paused,
                            out_res.peak_depth,
                            out_res.queued_cycles,
                            out_res.queue_depth,
                            out_scaled,
                            out_res.reg_value,
                            out_res.reg_addr,
                            out_res.target_sel};

endmodule

// ----- hdl/rfq_checker.sv -----
module rfq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  // no result offered straight after reset
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result offered after reset");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // without an event the event fields read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[32:0] == 33'd0)
    else $error("event fields set without an event");

  // a pure delay carries no register write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o && (m_axis_tdata_o[1:0] == 2'd0)
      |-> m_axis_tdata_o[14:2] == 13'd0)
    else $error("pure delay with address or value");

  // a drop only happens on a push, which returns no event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[88] |-> !m_axis_tuser_o)
    else $error("drop reported with a popped event");

endmodule

bind register_event_framer_queue_unit rfq_checker u_rfq_checker (.*);
